FILE: hw/rtl/lfr_pkg.sv
// Shared types and constants for the least-recently-unpinned frame replacer.
`timescale 1ns / 1ps

package lfr_pkg;

   localparam int FRAME_W     = 4;
   localparam int RSP_COUNT_W = 5;
   localparam int FRAME_IDS   = 1 << FRAME_W;

   localparam logic [1:0] MODE_VICTIM = 2'd0;
   localparam logic [1:0] MODE_PIN    = 2'd1;
   localparam logic [1:0] MODE_UNPIN  = 2'd2;

   typedef struct packed {
      logic               start;
      logic               is_victim;
      logic               is_unpin;
      logic [FRAME_W-1:0] frame;
   } scan_cmd_type;

   typedef struct packed {
      logic               done;
      logic [FRAME_W-1:0] victim;
   } scan_status_type;

endpackage

FILE: hw/rtl/lfr_channels.sv
// Request and response channel interfaces of the frame replacer.
`timescale 1ns / 1ps

interface lfr_req_if import lfr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [FRAME_W-1:0] frame;

   modport source (output valid, output mode, output frame, input ready);
   modport sink (input valid, input mode, input frame, output ready);
endinterface

interface lfr_rsp_if import lfr_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [FRAME_W-1:0]     victim_frame;
   logic [RSP_COUNT_W-1:0] evictable_count;

   modport source (output valid, output found, output victim_frame,
                   output evictable_count, input ready);
   modport sink (input valid, input found, input victim_frame,
                 input evictable_count, output ready);
endinterface

FILE: hw/rtl/lru_frame_replacer_unit.sv
// Top level of the least-recently-unpinned frame replacer.
`timescale 1ns / 1ps

// Usage: each request on req_chan carries one operation (victim, pin or unpin)
// and a frame index; each request yields exactly one response on rsp_chan with
// found, victim_frame and the number of evictable frames afterwards.
// The recency list lives in a single-port-write memory of NUM_FRAMES entries,
// oldest first. Unpin appends at the tail in the cycle the request is taken.
// Victim and pin stream the list through one comparator, one entry per cycle,
// closing the gap behind the removed entry as they go.
// Unpin, a pin of an untracked frame, a victim on an empty list and an unused
// mode go straight to the result. A victim or pin that removes an entry first
// streams all N entries through the scan, where N is the number of frames
// tracked when the request arrives. One request is in work at a time;
// req_chan.ready is low from acceptance until its result has been handed to
// the output register.
// Reset clears the tracked flags and the entry count; the list memory itself
// is not cleared and needs no clearing pass. A result waiting on a stalled
// receiver is held in the output register while the next request is worked on.

module lru_frame_replacer_unit import lfr_pkg::*; #(
   parameter int NUM_FRAMES = 16
) (
   input logic         clock,
   input logic         reset,
   lfr_req_if.sink     req_chan,
   lfr_rsp_if.source   rsp_chan
);

   localparam int CNT_W = $clog2(NUM_FRAMES + 1);

   typedef enum logic [1:0] {
      T_IDLE,
      T_BUSY,
      T_DONE
   } top_state_type;

   top_state_type          state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [FRAME_IDS-1:0]   flags_ff, flags_in;
   logic                   op_victim_ff, op_victim_in;
   logic                   pend_found_ff, pend_found_in;
   logic [FRAME_W-1:0]     pend_victim_ff, pend_victim_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [FRAME_W-1:0]     rsp_victim_ff, rsp_victim_in;
   logic [RSP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                   req_fire;
   logic                   frame_ok;
   logic                   frame_tracked;
   logic                   count_full;
   scan_cmd_type           scan_cmd;
   scan_status_type        scan_status;

   assign req_chan.ready = (state_ff == T_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign frame_ok       = (32'(req_chan.frame) < NUM_FRAMES);
   assign frame_tracked  = flags_ff[req_chan.frame];
   assign count_full     = (count_ff == CNT_W'(NUM_FRAMES));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      flags_in       = flags_ff;
      op_victim_in   = op_victim_ff;
      pend_found_in  = pend_found_ff;
      pend_victim_in = pend_victim_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_victim_in  = rsp_victim_ff;
      rsp_count_in   = rsp_count_ff;
      scan_cmd       = '0;
      scan_cmd.frame = req_chan.frame;
      case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               state_in       = T_DONE;
               op_victim_in   = 1'b0;
               pend_found_in  = 1'b0;
               pend_victim_in = '0;
               case (req_chan.mode)
                  MODE_VICTIM: begin
                     if (count_ff != '0) begin
                        scan_cmd.start     = 1'b1;
                        scan_cmd.is_victim = 1'b1;
                        count_in           = count_ff - CNT_W'(1);
                        op_victim_in       = 1'b1;
                        state_in           = T_BUSY;
                     end
                  end
                  MODE_PIN: begin
                     if (frame_ok && frame_tracked) begin
                        scan_cmd.start           = 1'b1;
                        flags_in[req_chan.frame] = 1'b0;
                        count_in                 = count_ff - CNT_W'(1);
                        state_in                 = T_BUSY;
                     end
                  end
                  MODE_UNPIN: begin
                     if (frame_ok && !frame_tracked && !count_full) begin
                        scan_cmd.start           = 1'b1;
                        scan_cmd.is_unpin        = 1'b1;
                        flags_in[req_chan.frame] = 1'b1;
                        count_in                 = count_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         T_BUSY: begin
            if (scan_status.done) begin
               state_in = T_DONE;
               if (op_victim_ff) begin
                  pend_found_in              = 1'b1;
                  pend_victim_in             = scan_status.victim;
                  flags_in[scan_status.victim] = 1'b0;
               end
            end
         end
         T_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in      = T_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_found_in  = pend_found_ff;
               rsp_victim_in = pend_victim_ff;
               rsp_count_in  = RSP_COUNT_W'(count_ff);
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         count_ff     <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_victim_ff   <= op_victim_in;
      pend_found_ff  <= pend_found_in;
      pend_victim_ff <= pend_victim_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_victim_ff  <= rsp_victim_in;
      rsp_count_ff   <= rsp_count_in;
   end

   lfr_scan_engine #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .cmd_in     (scan_cmd),
      .count_in   (count_ff),
      .status_out (scan_status)
   );

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.found           = rsp_found_ff;
   assign rsp_chan.victim_frame    = rsp_victim_ff;
   assign rsp_chan.evictable_count = rsp_count_ff;

   // Between requests the count must agree with the number of tracked flags.
   a_count_matches_flags: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_IDLE) |-> ($countones(flags_ff) == int'(count_ff)))
      else $error("entry count disagrees with tracked flags");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= NUM_FRAMES)
      else $error("entry count exceeds the number of frames");

   a_done_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      scan_status.done |-> (state_ff == T_BUSY))
      else $error("list scan finished with no removal in progress");

   a_found_only_with_frames: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.mode == MODE_VICTIM) && (count_ff == '0))
         |=> !pend_found_ff)
      else $error("victim reported on an empty list");

endmodule

FILE: hw/rtl/lfr_scan_engine.sv
// Recency list memory with the sequencer that appends, searches and closes gaps.
`timescale 1ns / 1ps

module lfr_scan_engine import lfr_pkg::*; #(
   parameter int NUM_FRAMES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  scan_cmd_type                      cmd_in,
   input  logic [$clog2(NUM_FRAMES+1)-1:0]   count_in,
   output scan_status_type                   status_out
);

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } eng_state_type;

   logic [FRAME_W-1:0] order_mem [NUM_FRAMES];

   eng_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               is_victim_ff, is_victim_in;
   logic [FRAME_W-1:0] key_ff, key_in;
   logic               shifting_ff, shifting_in;
   logic [FRAME_W-1:0] victim_ff, victim_in;
   logic               done_ff, done_in;
   logic               q_valid_ff;
   logic [IDX_W-1:0]   q_pos_ff;
   logic [FRAME_W-1:0] q_data_ff;

   logic               rd_issue;
   logic [IDX_W-1:0]   rd_addr;
   logic               hit;
   logic               take;
   logic               move;
   logic               at_last;
   logic               unpin_wr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [FRAME_W-1:0] mem_wdata;

   assign rd_issue = (state_ff == ST_SCAN) && (rd_pos_ff != cnt_ff);
   assign rd_addr  = rd_pos_ff[IDX_W-1:0];

   // The one comparator: a victim takes the head, a pin looks for its frame.
   assign hit     = is_victim_ff ? (q_pos_ff == '0) : (q_data_ff == key_ff);
   assign take    = q_valid_ff && !shifting_ff && hit;
   assign move    = q_valid_ff && shifting_ff;
   assign at_last = q_valid_ff && (CNT_W'(q_pos_ff) == (cnt_ff - CNT_W'(1)));

   // Entries after the removed one move down by one place as they stream past.
   assign unpin_wr  = cmd_in.start && cmd_in.is_unpin;
   assign mem_we    = unpin_wr || move;
   assign mem_waddr = unpin_wr ? count_in[IDX_W-1:0] : (q_pos_ff - IDX_W'(1));
   assign mem_wdata = unpin_wr ? cmd_in.frame : q_data_ff;

   always_comb begin
      state_in     = state_ff;
      rd_pos_in    = rd_pos_ff;
      cnt_in       = cnt_ff;
      is_victim_in = is_victim_ff;
      key_in       = key_ff;
      shifting_in  = shifting_ff;
      victim_in    = victim_ff;
      done_in      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_in.start && !cmd_in.is_unpin) begin
               state_in     = ST_SCAN;
               rd_pos_in    = '0;
               cnt_in       = count_in;
               is_victim_in = cmd_in.is_victim;
               key_in       = cmd_in.frame;
               shifting_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            if (rd_issue) begin
               rd_pos_in = rd_pos_ff + CNT_W'(1);
            end
            if (take) begin
               shifting_in = 1'b1;
               victim_in   = q_data_ff;
            end
            if (at_last) begin
               state_in = ST_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         done_ff    <= 1'b0;
         q_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         done_ff    <= done_in;
         q_valid_ff <= rd_issue;
      end
      rd_pos_ff    <= rd_pos_in;
      cnt_ff       <= cnt_in;
      is_victim_ff <= is_victim_in;
      key_ff       <= key_in;
      shifting_ff  <= shifting_in;
      victim_ff    <= victim_in;
      q_pos_ff     <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         order_mem[mem_waddr] <= mem_wdata;
      end
      q_data_ff <= order_mem[rd_addr];
   end

   assign status_out.done   = done_ff;
   assign status_out.victim = victim_ff;

endmodule

FILE: dv/tb_lru_frame_replacer_unit.sv
// Self-checking testbench for the least-recently-unpinned frame replacer.
`timescale 1ns / 1ps

module tb_lru_frame_replacer_unit;
   import lfr_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int ITEM_TARGET     = 1050;
   localparam int CALM_FROM       = 900;
   localparam int HOLD_OFF_AT     = 120;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 500000;

   // Shadow of the recency list: works out the response that each accepted
   // request must produce and compares the responses as they arrive.
   class lru_order_tracker;
      typedef struct {
         bit                   found;
         bit [FRAME_W-1:0]     victim;
         bit [RSP_COUNT_W-1:0] evictable;
      } evict_outcome_type;

      bit [FRAME_W-1:0]  lru_list[$];
      bit                tracked[FRAME_IDS];
      evict_outcome_type awaited_responses[$];
      int unsigned       failures;
      int unsigned       responses_checked;
      int unsigned       evictions;
      int unsigned       pins_removed;
      int unsigned       deepest;

      function void take_request(logic [1:0] mode, logic [FRAME_W-1:0] frame);
         evict_outcome_type want;
         int slot;
         want.found = 1'b0;
         want.victim = '0;
         slot = -1;
         case (mode)
            MODE_VICTIM: begin
               if (lru_list.size() > 0) begin
                  want.victim = lru_list.pop_front();
                  tracked[want.victim] = 1'b0;
                  want.found = 1'b1;
                  evictions++;
               end
            end
            MODE_PIN: begin
               if (tracked[frame]) begin
                  foreach (lru_list[i]) if (lru_list[i] == frame) slot = i;
                  if (slot >= 0) lru_list.delete(slot);
                  tracked[frame] = 1'b0;
                  pins_removed++;
               end
            end
            MODE_UNPIN: begin
               // A frame that is already tracked keeps its place in the list.
               if (!tracked[frame] && lru_list.size() < FRAME_IDS) begin
                  lru_list.push_back(frame);
                  tracked[frame] = 1'b1;
               end
            end
            default: ;
         endcase
         want.evictable = RSP_COUNT_W'(lru_list.size());
         if (lru_list.size() > deepest) deepest = lru_list.size();
         awaited_responses.push_back(want);
      endfunction

      function void compare_response(logic found, logic [FRAME_W-1:0] victim,
                                     logic [RSP_COUNT_W-1:0] evictable);
         evict_outcome_type want;
         if (awaited_responses.size() == 0) begin
            $error("response with no request outstanding: found %0d victim_frame %0d",
                   found, victim);
            failures++;
         end else begin
            want = awaited_responses.pop_front();
            responses_checked++;
            if (found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, found);
               failures++;
            end
            if (victim !== want.victim) begin
               $error("victim_frame: expected %0d, actual %0d", want.victim, victim);
               failures++;
            end
            if (evictable !== want.evictable) begin
               $error("evictable_count: expected %0d, actual %0d", want.evictable,
                      evictable);
               failures++;
            end
         end
      endfunction

      function logic [FRAME_W-1:0] any_tracked();
         if (lru_list.size() == 0) return FRAME_W'($urandom);
         return lru_list[$urandom_range(0, lru_list.size() - 1)];
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned cycle_count;
   int unsigned items_sent;
   int unsigned long_holds;
   bit calm;
   bit hold_off_asked;
   int sender_gap_pct;

   lfr_req_if req_chan();
   lfr_rsp_if rsp_chan();

   lru_order_tracker lru_shadow = new();

   lru_frame_replacer_unit #(.NUM_FRAMES(FRAME_IDS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      cycle_count = 0;
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d responses outstanding", cycle_count,
               lru_shadow.awaited_responses.size());
      $display("Test completed with failures");
      $finish;
   end

   // Both handshakes are observed here, at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            lru_shadow.take_request(req_chan.mode, req_chan.frame);
         if (rsp_chan.valid && rsp_chan.ready)
            lru_shadow.compare_response(rsp_chan.found, rsp_chan.victim_frame,
                                        rsp_chan.evictable_count);
      end
   end

   // Response side: random stalls, long ready stretches and one long hold-off.
   initial begin
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_asked) begin
            hold_off_asked = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            long_holds++;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(30, 60)) @(negedge clock);
            else repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   // Called at a falling edge; returns at a falling edge with valid still high
   // unless an idle gap was inserted.
   task automatic send_request(input logic [1:0] mode, input logic [FRAME_W-1:0] frame);
      req_chan.valid <= 1'b1;
      req_chan.mode  <= mode;
      req_chan.frame <= frame;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (mode != MODE_SPARE) items_sent++;
      @(negedge clock);
      if (!calm && $urandom_range(1, 100) <= sender_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   task automatic send_mixed(input int ops);
      int pick;
      repeat (ops) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            send_request(MODE_UNPIN, FRAME_W'($urandom));
         else if (pick < 65)
            send_request(MODE_PIN, ($urandom_range(0, 9) < 7) ? lru_shadow.any_tracked()
                                                                : FRAME_W'($urandom));
         else if (pick < 95)
            send_request(MODE_VICTIM, FRAME_W'($urandom));
         else
            send_request(MODE_SPARE, FRAME_W'($urandom));
      end
   endtask

   task automatic fill_and_drain();
      logic [FRAME_W-1:0] order[FRAME_IDS];
      logic [FRAME_W-1:0] swap;
      int j;
      for (int i = 0; i < FRAME_IDS; i++) order[i] = FRAME_W'(i);
      for (int i = FRAME_IDS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      foreach (order[i]) send_request(MODE_UNPIN, order[i]);
      repeat ($urandom_range(6, 20)) begin
         if ($urandom_range(0, 1) == 0) send_request(MODE_VICTIM, FRAME_W'($urandom));
         else send_request(MODE_PIN, lru_shadow.any_tracked());
      end
   endtask

   initial begin
      bit hold_done;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_VICTIM;
      req_chan.frame = '0;
      items_sent = 0;
      long_holds = 0;
      calm = 1'b0;
      hold_off_asked = 1'b0;
      hold_done = 1'b0;
      sender_gap_pct = 20;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty list, repeated unpin, removal at head, middle and tail.
      send_request(MODE_VICTIM, 4'd15);
      send_request(MODE_PIN, 4'd0);
      send_request(MODE_UNPIN, 4'd0);
      send_request(MODE_UNPIN, 4'd15);
      send_request(MODE_UNPIN, 4'd0);
      send_request(MODE_SPARE, 4'd10);
      send_request(MODE_PIN, 4'd7);
      send_request(MODE_UNPIN, 4'd9);
      send_request(MODE_UNPIN, 4'd3);
      send_request(MODE_PIN, 4'd9);
      send_request(MODE_PIN, 4'd3);
      send_request(MODE_PIN, 4'd0);
      send_request(MODE_UNPIN, 4'd6);
      send_request(MODE_VICTIM, 4'd0);
      send_request(MODE_VICTIM, 4'd5);
      send_request(MODE_VICTIM, 4'd0);
      send_request(MODE_UNPIN, 4'd15);
      send_request(MODE_PIN, 4'd15);
      send_request(MODE_VICTIM, 4'd15);

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= HOLD_OFF_AT && !hold_done) begin
            hold_off_asked = 1'b1;
            hold_done = 1'b1;
         end
         if (items_sent >= CALM_FROM) calm = 1'b1;
         sender_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
         case ($urandom_range(0, 3))
            0:       fill_and_drain();
            3:       repeat ($urandom_range(5, 10))
                        send_request(2'($urandom), FRAME_W'($urandom));
            default: send_mixed($urandom_range(10, 30));
         endcase
      end
      req_chan.valid <= 1'b0;

      while (lru_shadow.awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d evictions, %0d pins that removed a frame,",
               items_sent, lru_shadow.evictions, lru_shadow.pins_removed);
      $display("list depth up to %0d, %0d responses checked, %0d long receiver hold-offs.",
               lru_shadow.deepest, lru_shadow.responses_checked, long_holds);
      if (lru_shadow.failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
